// ===== src/swpm_pkg.sv =====
// Shared types and constants for the sleep/wake power-mode controller.
`timescale 1ns / 1ps

package swpm_pkg;

	// Operation codes carried in s_axis_tuser
	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_ACTIVITY = 2'd1,
		OP_WAKE     = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	// Power modes
	localparam logic [1:0] MODE_RUNNING = 2'd0;
	localparam logic [1:0] MODE_BG      = 2'd1;
	localparam logic [1:0] MODE_SLEEP   = 2'd2;

	localparam logic [31:0] NO_DEADLINE = 32'd0;

	// Register map (byte address bit 2 selects the register)
	localparam logic REG_IDLE_TIMEOUT = 1'b0;
	localparam logic REG_WAKE_PERIOD  = 1'b1;

	localparam logic [15:0] WAKE_PERIOD_RESET = 16'd60;

	// Configuration handed from the register file to the decision logic
	typedef struct packed {
		logic [15:0] idle_timeout;
		logic [15:0] wake_period;
	} cfg_t;

	// One input item
	typedef struct packed {
		op_t         op;
		logic [31:0] rtc_time;
		logic        button_event;
		logic        sleep_permitted;
		logic        alarm_fired;
	} item_t;

	// Controller state
	typedef struct packed {
		logic [1:0]  power_mode;
		logic [31:0] sleep_deadline;
	} state_t;

	// One result item
	typedef struct packed {
		logic        alarm_disarm;
		logic [31:0] alarm_time;
		logic        alarm_arm;
		logic        display_disable;
		logic        display_enable;
		logic [1:0]  mode;
	} result_t;

endpackage

// ===== src/swpm_cfg_regs.sv =====
// APB register file holding the idle timeout and wake_period.
`timescale 1ns / 1ps

module swpm_cfg_regs import swpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [15:0] idle_timeout_q;
	logic [15:0] wake_period_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Write registers on the access phase of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= 16'd0;
			wake_period_q  <= WAKE_PERIOD_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_IDLE_TIMEOUT) begin
				idle_timeout_q <= pwdata[15:0];
			end else begin
				wake_period_q <= pwdata[15:0];
			end
		end
	end

	// Read back the selected register
	always_comb begin
		if (paddr[2] == REG_WAKE_PERIOD) begin
			prdata = {16'd0, wake_period_q};
		end else begin
			prdata = {16'd0, idle_timeout_q};
		end
	end

	assign cfg.idle_timeout = idle_timeout_q;
	assign cfg.wake_period  = wake_period_q;

endmodule

// ===== src/swpm_decide.sv =====
// Next-state and result logic for one item of the power-mode controller.
`timescale 1ns / 1ps

module swpm_decide import swpm_pkg::*; (
	input  item_t   item,
	input  state_t  cur,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	logic [31:0] sched_deadline;
	logic        dl_not_due;

	// Deadline from the current time, or none when the timeout is off
	assign sched_deadline = (cfg.idle_timeout == 16'd0) ? NO_DEADLINE :
		item.rtc_time + {16'd0, cfg.idle_timeout};

	assign dl_not_due = (cur.sleep_deadline == NO_DEADLINE) ||
		(cur.sleep_deadline > item.rtc_time);

	always_comb begin
		nxt                 = cur;
		res.display_enable  = 1'b0;
		res.display_disable = 1'b0;
		res.alarm_arm       = 1'b0;
		res.alarm_time      = 32'd0;
		res.alarm_disarm    = 1'b0;
		case (item.op)
			OP_TICK: begin
				if (cur.power_mode == MODE_SLEEP) begin
					// stay asleep
				end else if (cur.power_mode == MODE_BG && item.button_event) begin
					nxt.power_mode     = MODE_RUNNING;
					res.display_enable = 1'b1;
				end else if (cur.power_mode == MODE_BG && !item.sleep_permitted) begin
					// wait for permission
				end else if (cur.power_mode == MODE_RUNNING &&
						(!item.sleep_permitted || dl_not_due)) begin
					// deadline not reached
				end else begin
					// enter sleep and arm the periodic wake alarm
					nxt.power_mode      = MODE_SLEEP;
					nxt.sleep_deadline  = NO_DEADLINE;
					res.display_disable = 1'b1;
					res.alarm_arm       = 1'b1;
					res.alarm_time      = item.rtc_time + {16'd0, cfg.wake_period};
				end
			end
			OP_ACTIVITY: begin
				nxt.sleep_deadline = sched_deadline;
			end
			OP_WAKE: begin
				if (cur.power_mode == MODE_SLEEP) begin
					res.alarm_disarm = 1'b1;
					if (item.alarm_fired) begin
						nxt.power_mode     = MODE_BG;
						nxt.sleep_deadline = NO_DEADLINE;
					end else if (item.button_event) begin
						nxt.power_mode     = MODE_RUNNING;
						nxt.sleep_deadline = sched_deadline;
						res.display_enable = 1'b1;
					end
				end
			end
			default: begin
				// unused code: no change
			end
		endcase
		res.mode = nxt.power_mode;
	end

endmodule

// ===== src/sleep_wake_power_mode_controller_core.sv =====
// An input transaction reaches the output via the input register and then the
// result register. Throughput: one item per cycle without result stalls; the
// single-pass decision logic between the two registers sets this, and the mode
// and deadline update in the same cycle an item leaves the input register.
// Reset: asynchronous, active low; mode running, no deadline, idle timeout 0,
// wake_period 60, both stages empty.
`timescale 1ns / 1ps

module sleep_wake_power_mode_controller_core import swpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // rtc_time[31:0], button_event[32],
	                                   // sleep_permitted[33], alarm_fired[34], zero[39:35]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // mode[1:0], display_enable[2], display_disable[3],
	                                   // alarm_arm[4], alarm_time[36:5], alarm_disarm[37],
	                                   // zero[39:38]
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_s2;
	logic    vld_s2;
	logic    advance;

	swpm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Move stage 1 forward when the result register is free or being taken
	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op              <= op_t'(s_axis_tuser);
			item_s1.rtc_time        <= s_axis_tdata[31:0];
			item_s1.button_event    <= s_axis_tdata[32];
			item_s1.sleep_permitted <= s_axis_tdata[33];
			item_s1.alarm_fired     <= s_axis_tdata[34];
		end
	end

	swpm_decide u_decide (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res)
	);

	// Commit mode and deadline as each item is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.power_mode     <= MODE_RUNNING;
			state_q.sleep_deadline <= NO_DEADLINE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {2'b00, res_s2.alarm_disarm, res_s2.alarm_time,
		res_s2.alarm_arm, res_s2.display_disable, res_s2.display_enable, res_s2.mode};

endmodule

// ===== bench/tb_sleep_wake_power_mode_controller_core.sv =====
// Stream-level regression bench for the sleep/wake power-mode controller core.
`timescale 1ns / 1ps

module tb_sleep_wake_power_mode_controller_core;
	import swpm_pkg::*;

	// Tracks mode, deadline and registers; predicts one outcome per accepted transaction
	class mode_outcome_tracker;
		logic [1:0]  mode;
		logic [31:0] deadline;
		logic [15:0] timeout_cfg;
		logic [15:0] period_cfg;
		result_t     expected_outcomes[$];
		int          accepted_total;
		int          errors;

		function new();
			mode = MODE_RUNNING;
			deadline = NO_DEADLINE;
			timeout_cfg = 16'd0;
			period_cfg = WAKE_PERIOD_RESET;
			accepted_total = 0;
			errors = 0;
		endfunction

		task log_mismatch(string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		function void apply_register(logic idx, logic [15:0] value);
			if (idx == REG_IDLE_TIMEOUT) begin
				timeout_cfg = value;
			end else begin
				period_cfg = value;
			end
		endfunction

		// Deadline from now, or none when the timeout is disabled
		function logic [31:0] next_deadline(logic [31:0] now);
			if (timeout_cfg == 16'd0) begin
				return NO_DEADLINE;
			end
			return now + {16'd0, timeout_cfg};
		endfunction

		function void note_accepted(item_t it);
			result_t r;
			r = '0;
			accepted_total++;
			case (it.op)
				OP_TICK: begin
					if (mode == MODE_SLEEP) begin
					end else if (mode == MODE_BG && it.button_event) begin
						mode = MODE_RUNNING;
						r.display_enable = 1'b1;
					end else if (mode == MODE_BG && !it.sleep_permitted) begin
					end else if (mode == MODE_RUNNING && (!it.sleep_permitted ||
							deadline == NO_DEADLINE || deadline > it.rtc_time)) begin
					end else begin
						// enter sleep and arm the periodic wake alarm
						deadline = NO_DEADLINE;
						mode = MODE_SLEEP;
						r.display_disable = 1'b1;
						r.alarm_arm = 1'b1;
						r.alarm_time = it.rtc_time + {16'd0, period_cfg};
					end
				end
				OP_ACTIVITY: begin
					deadline = next_deadline(it.rtc_time);
				end
				OP_WAKE: begin
					if (mode == MODE_SLEEP) begin
						r.alarm_disarm = 1'b1;
						if (it.alarm_fired) begin
							mode = MODE_BG;
							deadline = NO_DEADLINE;
						end else if (it.button_event) begin
							mode = MODE_RUNNING;
							r.display_enable = 1'b1;
							deadline = next_deadline(it.rtc_time);
						end
					end
				end
				default: begin
				end
			endcase
			r.mode = mode;
			expected_outcomes.push_back(r);
		endfunction

		task check_outcome(logic [39:0] word);
			result_t got;
			result_t want;
			got = word[37:0];
			if (expected_outcomes.size() == 0) begin
				log_mismatch($sformatf("result %h with nothing pending", word));
				return;
			end
			want = expected_outcomes.pop_front();
			if (word[39:38] !== 2'b00)
				log_mismatch($sformatf("pad bits %b", word[39:38]));
			if (got.mode !== want.mode)
				log_mismatch($sformatf("mode %0d, want %0d", got.mode, want.mode));
			if (got.display_enable !== want.display_enable)
				log_mismatch($sformatf("display_enable %b, want %b",
					got.display_enable, want.display_enable));
			if (got.display_disable !== want.display_disable)
				log_mismatch($sformatf("display_disable %b, want %b",
					got.display_disable, want.display_disable));
			if (got.alarm_arm !== want.alarm_arm)
				log_mismatch($sformatf("alarm_arm %b, want %b", got.alarm_arm, want.alarm_arm));
			if (got.alarm_time !== want.alarm_time)
				log_mismatch($sformatf("alarm_time %h, want %h", got.alarm_time, want.alarm_time));
			if (got.alarm_disarm !== want.alarm_disarm)
				log_mismatch($sformatf("alarm_disarm %b, want %b",
					got.alarm_disarm, want.alarm_disarm));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // rtc_time[31:0], button_event[32], sleep_permitted[33],
	                             // alarm_fired[34], zero[39:35]
	logic [1:0]  s_axis_tuser;   // op[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // mode[1:0], display_enable[2], display_disable[3],
	                             // alarm_arm[4], alarm_time[36:5], alarm_disarm[37], zero[39:38]

	mode_outcome_tracker tracker;
	logic [31:0]         time_base;
	int                  sender_burst;

	sleep_wake_power_mode_controller_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_outcome(m_axis_tdata);
	end

	// Result side: short stalls, ready stretches, long stalls and one long hold-off
	initial begin
		int  stretch;
		int  r;
		bit  held;
		m_axis_tready = 1'b0;
		stretch = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && tracker != null && tracker.accepted_total >= 900) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end else if (stretch > 0) begin
				stretch--;
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					stretch = $urandom_range(30, 120);
					m_axis_tready <= 1'b1;
				end else if (r < 4) begin
					m_axis_tready <= 1'b0;
					repeat ($urandom_range(15, 40)) @(negedge clk);
				end else begin
					m_axis_tready <= (r >= 30);
				end
			end
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (sender_burst > 0) begin
			sender_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			sender_burst = $urandom_range(20, 80);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic item_t mk(op_t op, logic [31:0] rtc, logic btn, logic perm, logic alm);
		item_t it;
		it.op = op;
		it.rtc_time = rtc;
		it.button_event = btn;
		it.sleep_permitted = perm;
		it.alarm_fired = alm;
		return it;
	endfunction

	// Mostly well-formed sequences for the current mode, some noise
	function automatic item_t draft_item();
		item_t it;
		int    r;
		int    step;
		r = $urandom_range(0, 99);
		step = (tracker.timeout_cfg == 16'd0) ? 50 : tracker.timeout_cfg / 4 + 1;
		case ($urandom_range(0, 63))
			0, 1: time_base = $urandom;
			2: time_base = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
			default: time_base = time_base + 32'($urandom_range(0, step));
		endcase
		it = mk(OP_TICK, time_base, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		if (r < 8) begin
			it.op = op_t'($urandom_range(0, 3));
			it.rtc_time = $urandom;
		end else if (tracker.mode == MODE_SLEEP) begin
			it.op = (r < 75) ? OP_WAKE : (r < 90) ? OP_TICK : OP_ACTIVITY;
			it.alarm_fired = ($urandom_range(0, 9) < 4);
		end else if (tracker.mode == MODE_BG) begin
			it.op = (r < 65) ? OP_TICK : (r < 88) ? OP_ACTIVITY : OP_WAKE;
			it.button_event = ($urandom_range(0, 9) < 3);
		end else if (tracker.deadline == NO_DEADLINE) begin
			it.op = (r < 60) ? OP_ACTIVITY : (r < 90) ? OP_TICK : OP_WAKE;
		end else begin
			it.op = (r < 70) ? OP_TICK : (r < 90) ? OP_ACTIVITY : OP_WAKE;
			it.sleep_permitted = ($urandom_range(0, 9) < 8);
			// land right around the deadline
			if (it.op == OP_TICK && $urandom_range(0, 2) == 0) begin
				time_base = 32'(tracker.deadline + $urandom_range(0, 2) - 1);
				it.rtc_time = time_base;
			end
		end
		return it;
	endfunction

	// Called at a falling edge; returns at a falling edge after the gap
	task automatic offer_item(input item_t it);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {5'd0, it.alarm_fired, it.sleep_permitted, it.button_event,
			it.rtc_time};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_accepted(it);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has come
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.expected_outcomes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write one register, then read it back; called and returns at a falling edge
	task automatic set_register(input logic idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.apply_register(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'd0, value})
			tracker.log_mismatch($sformatf("register %0d reads %h, want %h",
				idx, prdata, value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] phase_timeout [6];
		logic [15:0] phase_period [6];
		item_t       it;
		int          counted;
		bit          ignored;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_TICK;
		time_base = 32'd0;
		sender_burst = 0;
		tracker = new();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: timeout disabled, so no sleep from running
		offer_item(mk(OP_TICK, 32'd5000, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_ACTIVITY, 32'd1000, 1'b0, 1'b0, 1'b0));
		offer_item(mk(OP_WAKE, 32'd1000, 1'b1, 1'b1, 1'b1));
		offer_item(mk(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
		drain();
		set_register(REG_IDLE_TIMEOUT, 16'd100);
		set_register(REG_WAKE_PERIOD, 16'd1);

		// Deadline boundary, permission, sleep, wake causes, wrap-around
		offer_item(mk(OP_ACTIVITY, 32'd1000, 1'b0, 1'b0, 1'b0));
		offer_item(mk(OP_TICK, 32'd1099, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_TICK, 32'd1100, 1'b0, 1'b0, 1'b0));
		offer_item(mk(OP_TICK, 32'd1100, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_TICK, 32'd1200, 1'b1, 1'b1, 1'b0));
		offer_item(mk(OP_ACTIVITY, 32'd1300, 1'b0, 1'b0, 1'b0));
		offer_item(mk(OP_WAKE, 32'd1400, 1'b1, 1'b0, 1'b1));
		offer_item(mk(OP_TICK, 32'd1500, 1'b0, 1'b0, 1'b0));
		offer_item(mk(OP_TICK, 32'd0, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_WAKE, 32'd10, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_WAKE, 32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0));
		offer_item(mk(OP_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_WAKE, 32'd20, 1'b0, 1'b0, 1'b1));
		offer_item(mk(OP_TICK, 32'd30, 1'b1, 1'b0, 1'b0));
		offer_item(mk(OP_ACTIVITY, 32'hFFFF_FF9C, 1'b0, 1'b0, 1'b0));
		offer_item(mk(OP_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
		drain();
		set_register(REG_IDLE_TIMEOUT, 16'hFFFF);
		set_register(REG_WAKE_PERIOD, 16'hFFFF);

		// Largest settings, then a wake period of zero
		offer_item(mk(OP_ACTIVITY, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
		offer_item(mk(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
		offer_item(mk(OP_WAKE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
		drain();
		set_register(REG_WAKE_PERIOD, 16'd0);
		offer_item(mk(OP_TICK, 32'd12345, 1'b0, 1'b1, 1'b0));
		offer_item(mk(OP_WAKE, 32'd12400, 1'b1, 1'b0, 1'b0));

		// Random phases, each under its own settings
		phase_timeout = '{16'd40, 16'd1, 16'hFFFF, 16'd0, 16'd300, 16'd0};
		phase_period = '{16'd60, 16'hFFFF, 16'd1, 16'd1000, 16'd0, 16'd0};
		phase_timeout[5] = 16'($urandom_range(2, 16'hFFFE));
		phase_period[5] = 16'($urandom_range(2, 16'hFFFE));
		for (int p = 0; p < 6; p++) begin
			drain();
			set_register(REG_IDLE_TIMEOUT, phase_timeout[p]);
			set_register(REG_WAKE_PERIOD, phase_period[p]);
			counted = 0;
			while (counted < 325) begin
				if (p == 4 && counted == 200)
					drain();
				it = draft_item();
				ignored = (it.op == OP_UNUSED) ||
					(it.op == OP_WAKE && tracker.mode != MODE_SLEEP);
				offer_item(it);
				if (!ignored)
					counted++;
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (tracker.expected_outcomes.size() != 0)
			tracker.log_mismatch("expected results left over at the end");
		if (tracker.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
